// ===== hdl/thart_pkg.sv =====
// ----------------------------------------------------------------------------
// thart_pkg
// Shared types, state codes and helpers for the touch-hold auto-repeat timer.
// ----------------------------------------------------------------------------
package thart_pkg;

  localparam int unsigned CntW  = 16;
  localparam int unsigned ModeW = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ModeW-1:0] MODE_START   = 4'd0;
  localparam logic [ModeW-1:0] MODE_INIT    = 4'd1;
  localparam logic [ModeW-1:0] MODE_FIRST   = 4'd2;
  localparam logic [ModeW-1:0] MODE_WAIT    = 4'd3;
  localparam logic [ModeW-1:0] MODE_SECOND  = 4'd4;
  localparam logic [ModeW-1:0] MODE_SETTLE  = 4'd5;
  localparam logic [ModeW-1:0] MODE_HOLD    = 4'd6;
  localparam logic [ModeW-1:0] MODE_REPEAT  = 4'd7;
  localparam logic [ModeW-1:0] MODE_EXPIRED = 4'd8;

  localparam logic [CfgIdxW-1:0] CFG_SECOND_TICKS     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_TICKS     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_DELAY_TICKS = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_TICKS     = 2'd3;

  localparam logic [CntW-1:0] SECOND_TICKS_RST     = 16'd20;
  localparam logic [CntW-1:0] SETTLE_TICKS_RST     = 16'd1;
  localparam logic [CntW-1:0] HOLD_DELAY_TICKS_RST = 16'd10;
  localparam logic [CntW-1:0] REPEAT_TICKS_RST     = 16'd2;

  localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};

  typedef struct packed {
    logic [CntW-1:0] second_ticks;
    logic [CntW-1:0] settle_ticks;
    logic [CntW-1:0] hold_delay_ticks;
    logic [CntW-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic             advance_second;
    logic             inc_dec_pulse;
    logic             consume_touch;
    logic [ModeW-1:0] mode_code;
  } result_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CntW'(1);
  endfunction

endpackage

// ===== hdl/thart_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// thart_cfg_regs
// Threshold registers written through the plain configuration port.
// ----------------------------------------------------------------------------
module thart_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [thart_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [thart_pkg::CntW-1:0]      cfg_wdata_i,
  output thart_pkg::cfg_t                 cfg_o
);

  thart_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.second_ticks     <= thart_pkg::SECOND_TICKS_RST;
      cfg_q.settle_ticks     <= thart_pkg::SETTLE_TICKS_RST;
      cfg_q.hold_delay_ticks <= thart_pkg::HOLD_DELAY_TICKS_RST;
      cfg_q.repeat_ticks     <= thart_pkg::REPEAT_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        thart_pkg::CFG_SECOND_TICKS:     cfg_q.second_ticks     <= cfg_wdata_i;
        thart_pkg::CFG_SETTLE_TICKS:     cfg_q.settle_ticks     <= cfg_wdata_i;
        thart_pkg::CFG_HOLD_DELAY_TICKS: cfg_q.hold_delay_ticks <= cfg_wdata_i;
        thart_pkg::CFG_REPEAT_TICKS:     cfg_q.repeat_ticks     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/thart_fsm.sv =====
// ----------------------------------------------------------------------------
// thart_fsm
// Nine-state touch controller with saturating tick counters, one tick per step.
// ----------------------------------------------------------------------------
module thart_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               touched_i,
  input  thart_pkg::cfg_t    cfg_i,
  output thart_pkg::result_t res_o
);

  logic [thart_pkg::ModeW-1:0] mode_q, mode_d;
  logic [thart_pkg::CntW-1:0]  settle_q, settle_d;
  logic [thart_pkg::CntW-1:0]  hold_q, hold_d;
  logic [thart_pkg::CntW-1:0]  repeat_q, repeat_d;
  logic [thart_pkg::CntW-1:0]  second_q, second_d;
  logic                        adv, inc, cons;

  // transition
  always_comb begin
    mode_d = mode_q;
    adv    = 1'b0;
    inc    = 1'b0;
    cons   = 1'b0;
    case (mode_q)
      thart_pkg::MODE_START: mode_d = thart_pkg::MODE_INIT;
      thart_pkg::MODE_INIT:  mode_d = thart_pkg::MODE_FIRST;
      thart_pkg::MODE_FIRST: begin
        if (touched_i) begin
          mode_d = thart_pkg::MODE_WAIT;
          cons   = 1'b1;
        end
      end
      thart_pkg::MODE_WAIT: begin
        if (touched_i) begin
          mode_d = thart_pkg::MODE_SETTLE;
          cons   = 1'b1;
        end else if (second_q >= cfg_i.second_ticks) begin
          mode_d = thart_pkg::MODE_SECOND;
        end
      end
      thart_pkg::MODE_SECOND: begin
        mode_d = thart_pkg::MODE_WAIT;
        adv    = 1'b1;
      end
      thart_pkg::MODE_SETTLE: begin
        if (settle_q >= cfg_i.settle_ticks) begin
          if (touched_i) begin
            mode_d = thart_pkg::MODE_HOLD;
          end else begin
            mode_d = thart_pkg::MODE_WAIT;
            inc    = 1'b1;
          end
        end
      end
      thart_pkg::MODE_HOLD: begin
        if (!touched_i) begin
          mode_d = thart_pkg::MODE_WAIT;
          inc    = 1'b1;
        end else if (hold_q >= cfg_i.hold_delay_ticks) begin
          mode_d = thart_pkg::MODE_REPEAT;
          inc    = 1'b1;
        end
      end
      thart_pkg::MODE_REPEAT: begin
        if (!touched_i) begin
          mode_d = thart_pkg::MODE_WAIT;
        end else if (repeat_q >= cfg_i.repeat_ticks) begin
          mode_d = thart_pkg::MODE_EXPIRED;
        end
      end
      thart_pkg::MODE_EXPIRED: begin
        if (!touched_i) begin
          mode_d = thart_pkg::MODE_WAIT;
        end else begin
          mode_d = thart_pkg::MODE_REPEAT;
          inc    = 1'b1;
        end
      end
      default: mode_d = thart_pkg::MODE_START;
    endcase
  end

  // counter action of the new state
  always_comb begin
    settle_d = settle_q;
    hold_d   = hold_q;
    repeat_d = repeat_q;
    second_d = second_q;
    case (mode_d)
      thart_pkg::MODE_INIT: begin
        settle_d = '0;
        hold_d   = '0;
        repeat_d = '0;
        second_d = '0;
      end
      thart_pkg::MODE_WAIT: begin
        settle_d = '0;
        hold_d   = '0;
        repeat_d = '0;
        second_d = thart_pkg::sat_inc(second_q);
      end
      thart_pkg::MODE_SECOND:  second_d = '0;
      thart_pkg::MODE_SETTLE:  settle_d = thart_pkg::sat_inc(settle_q);
      thart_pkg::MODE_HOLD:    hold_d   = thart_pkg::sat_inc(hold_q);
      thart_pkg::MODE_REPEAT:  repeat_d = thart_pkg::sat_inc(repeat_q);
      thart_pkg::MODE_EXPIRED: repeat_d = '0;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= thart_pkg::MODE_START;
      settle_q <= '0;
      hold_q   <= '0;
      repeat_q <= '0;
      second_q <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      settle_q <= settle_d;
      hold_q   <= hold_d;
      repeat_q <= repeat_d;
      second_q <= second_d;
    end
  end

  assign res_o.advance_second = adv;
  assign res_o.inc_dec_pulse  = inc;
  assign res_o.consume_touch  = cons;
  assign res_o.mode_code      = mode_d;

endmodule

// ===== hdl/touch_hold_auto_repeat_timer.sv =====
// ----------------------------------------------------------------------------
// touch_hold_auto_repeat_timer
// Touch-hold auto-repeat timer: one touch sample in, one result per tick out.
// ----------------------------------------------------------------------------
// path: an input transfer is held in the input register, then in the
//   result register, from which its result is shown
// throughput: one tick per cycle unless the output stalls
// reset: asynchronous, active low; state to start, counters to zero,
//   thresholds to 20, 1, 10 and 2 ticks, both pipeline registers empty
module touch_hold_auto_repeat_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          touched_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          advance_second_o,
  output logic                          inc_dec_pulse_o,
  output logic                          consume_touch_o,
  output logic [thart_pkg::ModeW-1:0]   mode_code_o,
  input  logic                          cfg_we_i,
  input  logic [thart_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [thart_pkg::CntW-1:0]    cfg_wdata_i
);

  thart_pkg::cfg_t    cfg;
  thart_pkg::result_t res;
  thart_pkg::result_t res_q;

  logic in_valid_q;
  logic touched_q;
  logic out_valid_q;
  logic out_free;
  logic step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  thart_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  thart_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .touched_i (touched_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      touched_q <= touched_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign advance_second_o = res_q.advance_second;
  assign inc_dec_pulse_o  = res_q.inc_dec_pulse;
  assign consume_touch_o  = res_q.consume_touch;
  assign mode_code_o      = res_q.mode_code;

endmodule
